[rtl/csm_pkg.sv]
package csm_pkg;

  localparam int unsigned MinuteW  = 60;
  localparam int unsigned HourW    = 24;
  localparam int unsigned DayW     = 31;
  localparam int unsigned MonthW   = 12;
  localparam int unsigned WeekdayW = 7;
  localparam int unsigned CfgDataW = 60;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 8;

  // Shifted year: year plus a multiple of 400 (weekday-neutral), plus a
  // carry of -1, 0 or +1 from the month normalization.
  localparam int unsigned YW = 13;
  // Quotient of the shifted year by 4 and by 100.
  localparam int unsigned QW    = YW - 2;
  localparam int unsigned CentW = 6;
  // floor(q / 25) == (q * Recip25) >> Recip25Shift for every q below 1225.
  localparam int unsigned Recip25      = 1311;
  localparam int unsigned Recip25Shift = 15;
  localparam int unsigned ProdW        = QW + 11;
  // Weekday sum before the mod 7 fold.
  localparam int unsigned SumW = 15;

  typedef enum logic [2:0] {
    RegMinuteMask  = 3'd0,
    RegHourMask    = 3'd1,
    RegDayMask     = 3'd2,
    RegMonthMask   = 3'd3,
    RegWeekdayMask = 3'd4,
    RegDayAny      = 3'd5,
    RegWeekdayAny  = 3'd6
  } csm_reg_e;

  typedef struct packed {
    logic [MinuteW-1:0]  minute_mask;
    logic [HourW-1:0]    hour_mask;
    logic [DayW-1:0]     day_mask;
    logic [MonthW-1:0]   month_mask;
    logic [WeekdayW-1:0] weekday_mask;
    logic                day_any;
    logic                weekday_any;
  } csm_cfg_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } csm_time_t;

  typedef struct packed {
    logic [YW-1:0]    year_adj;
    logic [CentW-1:0] cent;
    logic [2:0]       month_off;
    logic [4:0]       day;
    logic             base_ok;
    logic             day_fit;
  } csm_mid_t;

  // Month offset of the weekday formula, indexed by the raw month code.
  // Month 0 is December of the year before; months 13 to 15 are January
  // to March of the year after.
  function automatic logic [2:0] month_offset(input logic [3:0] month);
    logic [2:0] off;
    case (month)
      4'd0:    off = 3'd4;
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      4'd13:   off = 3'd0;
      4'd14:   off = 3'd3;
      default: off = 3'd2;
    endcase
    return off;
  endfunction

  // Year bias for the month code: 800 less one for January, February and
  // the December of the year before, 800 plus one for March of next year.
  function automatic logic [YW-1:0] year_bias(input logic [3:0] month);
    logic [YW-1:0] bias;
    if (month <= 4'd2) begin
      bias = YW'(799);
    end else if (month == 4'd15) begin
      bias = YW'(801);
    end else begin
      bias = YW'(800);
    end
    return bias;
  endfunction

endpackage

[rtl/csm_cfg_regs.sv]
module csm_cfg_regs
  import csm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output csm_cfg_t            cfg_o
);

  csm_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMinuteMask:  cfg_d.minute_mask  = cfg_wdata_i[MinuteW-1:0];
        RegHourMask:    cfg_d.hour_mask    = cfg_wdata_i[HourW-1:0];
        RegDayMask:     cfg_d.day_mask     = cfg_wdata_i[DayW-1:0];
        RegMonthMask:   cfg_d.month_mask   = cfg_wdata_i[MonthW-1:0];
        RegWeekdayMask: cfg_d.weekday_mask = cfg_wdata_i[WeekdayW-1:0];
        RegDayAny:      cfg_d.day_any      = cfg_wdata_i[0];
        RegWeekdayAny:  cfg_d.weekday_any  = cfg_wdata_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{minute_mask: '0, hour_mask: '0, day_mask: '0, month_mask: '0,
                 weekday_mask: '0, day_any: 1'b1, weekday_any: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/csm_input_stage.sv]
module csm_input_stage
  import csm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [InDataW-1:0] data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output csm_time_t          time_o
);

  logic      valid_q;
  csm_time_t time_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      time_q.year   <= data_i[11:0];
      time_q.month  <= data_i[15:12];
      time_q.day    <= data_i[20:16];
      time_q.hour   <= data_i[25:21];
      time_q.minute <= data_i[31:26];
    end
  end

  assign valid_o = valid_q;
  assign time_o  = time_q;

endmodule

[rtl/csm_field_stage.sv]
module csm_field_stage
  import csm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  csm_cfg_t  cfg_i,
  input  logic      valid_i,
  output logic      ready_o,
  input  csm_time_t time_i,
  output logic      valid_o,
  input  logic      ready_i,
  output csm_mid_t  mid_o
);

  logic          valid_q;
  csm_mid_t      mid_q, mid_d;
  logic [QW-1:0] quad;
  logic [ProdW-1:0] prod;
  logic          masks_set;
  logic          minute_fit, hour_fit, month_fit;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    mid_d.year_adj  = YW'(time_i.year) + year_bias(time_i.month);
    quad            = mid_d.year_adj[YW-1:2];
    // Century count as floor(year / 4) / 25 by a reciprocal multiply.
    prod            = ProdW'(quad) * ProdW'(Recip25);
    mid_d.cent      = prod[Recip25Shift +: CentW];
    mid_d.month_off = month_offset(time_i.month);
    mid_d.day       = time_i.day;

    masks_set  = (cfg_i.minute_mask != '0) && (cfg_i.hour_mask != '0) &&
                 (cfg_i.day_mask != '0) && (cfg_i.month_mask != '0) &&
                 (cfg_i.weekday_mask != '0);
    minute_fit = (time_i.minute < 6'd60) && cfg_i.minute_mask[time_i.minute];
    hour_fit   = (time_i.hour < 5'd24) && cfg_i.hour_mask[time_i.hour];
    month_fit  = (time_i.month != 4'd0) && (time_i.month <= 4'd12) &&
                 cfg_i.month_mask[time_i.month - 4'd1];
    mid_d.base_ok = masks_set && minute_fit && hour_fit && month_fit;
    mid_d.day_fit = (time_i.day != 5'd0) && cfg_i.day_mask[time_i.day - 5'd1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mid_q <= mid_d;
    end
  end

  assign valid_o = valid_q;
  assign mid_o   = mid_q;

endmodule

[rtl/csm_weekday_stage.sv]
module csm_weekday_stage
  import csm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csm_cfg_t            cfg_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  csm_mid_t            mid_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [OutDataW-1:0] data_o
);

  logic            valid_q;
  logic            matched_q, matched_d;
  logic [2:0]      weekday_q, weekday_d;
  logic [SumW-1:0] sum;
  logic [5:0]      fold1;
  logic [3:0]      fold2;
  logic            wday_fit;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    sum = SumW'(mid_i.year_adj) + SumW'(mid_i.year_adj[YW-1:2]) +
          SumW'(mid_i.cent[CentW-1:2]) + SumW'(mid_i.month_off) +
          SumW'(mid_i.day) - SumW'(mid_i.cent);
    // Since 8 is 1 modulo 7, summing octal digits keeps the residue.
    fold1 = 6'(sum[2:0]) + 6'(sum[5:3]) + 6'(sum[8:6]) + 6'(sum[11:9]) +
            6'(sum[14:12]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    weekday_d = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

    wday_fit = cfg_i.weekday_mask[weekday_d];
    if (cfg_i.day_any && cfg_i.weekday_any) begin
      matched_d = mid_i.base_ok;
    end else if (!cfg_i.day_any && !cfg_i.weekday_any) begin
      matched_d = mid_i.base_ok && (mid_i.day_fit || wday_fit);
    end else begin
      matched_d = mid_i.base_ok && mid_i.day_fit && wday_fit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      matched_q <= matched_d;
      weekday_q <= weekday_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = {(OutDataW - 4)'(0), weekday_q, matched_q};

endmodule

[rtl/cron_schedule_match_core.sv]
// Cron schedule matcher. Each input beat carries one calendar time and
// produces exactly one output beat that says whether the time fits the
// schedule held in the configuration registers, together with the computed
// day of week (0 is Sunday), which is given whatever the match result. The
// block is a three-stage pipeline: an input register, a field stage that
// checks the minute, hour, month and day masks and forms the century count
// with one small constant multiply, and a result stage that reduces the
// weekday sum modulo 7 and applies the cron day/weekday rule. It takes one
// beat per clock cycle. An accepted beat moves through the input, field
// and result registers in turn, and output valid rises as it enters the
// last of them. The rate is set by the ready chain through the three stage
// registers, which only holds off input while the output is stalled.
// Configuration must be written only while the pipeline is empty. After
// reset all masks are zero, so nothing matches until they are written.
module cron_schedule_match_core
  import csm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  // Configuration write port; index follows the register list.
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,

  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // Fields from bit 0 up: year[11:0], month[15:12], day[20:16],
  // hour[25:21], minute[31:26].
  input  logic [InDataW-1:0]  s_axis_tdata_i,

  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // Fields from bit 0 up: matched[0], weekday[3:1], zero padding[7:4].
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  csm_cfg_t  cfg;
  csm_time_t in_time;
  csm_mid_t  mid;
  logic      a_valid, a_ready;
  logic      b_valid, b_ready;

  // The user must keep the registers static while beats are in flight; the
  // block does not enforce it. Both compute stages read them directly.
  csm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Stage A captures the raw beat and unpacks its fields.
  csm_input_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .valid_o (a_valid),
    .ready_i (a_ready),
    .time_o  (in_time)
  );

  // Stage B evaluates the per-field masks and the year terms of the
  // weekday formula.
  csm_field_stage u_field (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (a_valid),
    .ready_o (a_ready),
    .time_i  (in_time),
    .valid_o (b_valid),
    .ready_i (b_ready),
    .mid_o   (mid)
  );

  // Stage C finishes the weekday and combines the day rules; its register
  // is the output register.
  csm_weekday_stage u_wday (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (b_valid),
    .ready_o (b_ready),
    .mid_i   (mid),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (m_axis_tdata_o)
  );

endmodule

[rtl/csm_checker.sv]
module csm_checker
  import csm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  // A stalled output beat stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat changed while stalled");

  // The weekday of a valid output beat is always in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[3:1] != 3'd7)
    else $error("weekday out of range");

  // Input is held off only when a result is stalled at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // With the output always ready, an accepted beat passes the input, field
  // and result registers and is then presented at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && m_axis_tready_i) ##1 m_axis_tready_i
      ##1 m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result missing three cycles after acceptance");

endmodule

bind cron_schedule_match_core csm_checker u_csm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

[bench/tb_cron_schedule_match_core.sv]
module tb_cron_schedule_match_core;
  timeunit 1ns;
  timeprecision 1ps;

  import csm_pkg::*;

  // Clock period is 20 ns. The limit below is far beyond the slowest correct run.
  localparam int unsigned ResetCycles   = 10;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned PhaseItems    = 125;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned DrainCycles   = 10;

  // One expected output beat, with the time that caused it kept for messages.
  typedef struct {
    csm_time_t  stamp;
    logic       matched;
    logic [2:0] weekday;
  } verdict_t;

  // How the receiver drives tready during one stretch of cycles.
  typedef enum int unsigned {
    RxAlways,
    RxCoin,
    RxSparse,
    RxToggle
  } rx_mode_e;

  // How one schedule is chosen before a phase of stimulus.
  typedef enum int unsigned {
    SchedOnes,
    SchedZero,
    SchedRandom
  } sched_kind_e;

  // Kinds of mask that the random schedules are built from.
  typedef enum int unsigned {
    MaskZero,
    MaskOnes,
    MaskDense,
    MaskRandom,
    MaskSingle
  } mask_mode_e;

  // The scoreboard keeps its own copy of the schedule registers, predicts
  // the verdict of every accepted time and checks output beats in order.
  class schedule_scoreboard;
    csm_cfg_t    cfg;
    verdict_t    verdict_q[$];
    int unsigned mismatches;

    function new();
      cfg             = '0;
      cfg.day_any     = 1'b1;
      cfg.weekday_any = 1'b1;
      mismatches      = 0;
    endfunction

    function void set_reg(input csm_reg_e idx, input logic [CfgDataW-1:0] value);
      case (idx)
        RegMinuteMask:  cfg.minute_mask  = value[MinuteW-1:0];
        RegHourMask:    cfg.hour_mask    = value[HourW-1:0];
        RegDayMask:     cfg.day_mask     = value[DayW-1:0];
        RegMonthMask:   cfg.month_mask   = value[MonthW-1:0];
        RegWeekdayMask: cfg.weekday_mask = value[WeekdayW-1:0];
        RegDayAny:      cfg.day_any      = value[0];
        RegWeekdayAny:  cfg.weekday_any  = value[0];
        default: ;
      endcase
    endfunction

    // Gregorian day of week. The year is moved up by 800, which keeps the
    // weekday and keeps every term positive. Month 0 counts as December of
    // the year before and months 13 to 15 as early months of the next one.
    function logic [2:0] day_of_week(input csm_time_t t);
      int unsigned yr;
      int unsigned mi;
      int unsigned offs [12];
      offs = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
      yr = t.year + 800;
      if (t.month == 4'd0) begin
        yr = yr - 1;
        mi = 11;
      end else if (t.month > 4'd12) begin
        yr = yr + 1;
        mi = t.month - 13;
      end else begin
        mi = t.month - 1;
      end
      if (mi < 2) begin
        yr = yr - 1;
      end
      return 3'((yr + yr / 4 - yr / 100 + yr / 400 + offs[mi] + t.day) % 7);
    endfunction

    function verdict_t predict_verdict(input csm_time_t t);
      verdict_t v;
      logic     base_ok;
      logic     day_fit;
      logic     wday_fit;
      v.stamp   = t;
      v.weekday = day_of_week(t);
      // Any empty mask marks an invalid field, so nothing can match.
      base_ok = cfg.minute_mask != '0 && cfg.hour_mask != '0 && cfg.day_mask != '0 &&
                cfg.month_mask != '0 && cfg.weekday_mask != '0 &&
                t.minute < 6'd60 && cfg.minute_mask[t.minute] &&
                t.hour < 5'd24 && cfg.hour_mask[t.hour] &&
                t.month != 4'd0 && t.month <= 4'd12 &&
                cfg.month_mask[4'(t.month - 4'd1)];
      day_fit  = t.day != 5'd0 && cfg.day_mask[5'(t.day - 5'd1)];
      wday_fit = v.weekday != 3'd7 && cfg.weekday_mask[v.weekday];
      if (!base_ok) begin
        v.matched = 1'b0;
      end else if (cfg.day_any && cfg.weekday_any) begin
        v.matched = 1'b1;
      end else if (!cfg.day_any && !cfg.weekday_any) begin
        v.matched = day_fit || wday_fit;
      end else begin
        v.matched = day_fit && wday_fit;
      end
      return v;
    endfunction

    function void note_time(input csm_time_t t);
      verdict_q.insert(verdict_q.size(), predict_verdict(t));
    endfunction

    function void check_result(input logic [OutDataW-1:0] beat);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: output beat %h arrived with no time pending", beat);
        end
        return;
      end
      want = verdict_q.pop_front();
      if (beat[0] !== want.matched || beat[3:1] !== want.weekday ||
          beat[OutDataW-1:4] !== '0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: time %0d-%0d-%0d %0d:%0d expected matched %0d weekday %0d, got matched %0d weekday %0d pad %h",
                   want.stamp.year, want.stamp.month, want.stamp.day, want.stamp.hour,
                   want.stamp.minute, want.matched, want.weekday, beat[0], beat[3:1],
                   beat[OutDataW-1:4]);
        end
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [2:0]          cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  // Fields from bit 0 up: year[11:0], month[15:12], day[20:16],
  // hour[25:21], minute[31:26].
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  // Fields from bit 0 up: matched[0], weekday[3:1], zero padding[7:4].
  logic [OutDataW-1:0] m_axis_tdata_o;

  schedule_scoreboard sb = new();

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit          hold_off_req = 1'b0;
  // Beats left in the current sender burst.
  int unsigned burst_left = 0;

  cron_schedule_match_core i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Offers one time on the input stream and returns at the edge where the
  // beat is taken. The sender works in bursts: when a burst runs out, valid
  // drops for a random gap (sometimes none) and a new burst length is drawn.
  // Valid is only lowered in a gap, so back-to-back beats keep it high.
  task automatic send_time(input csm_time_t t);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {t.minute, t.hour, t.day, t.month, t.year};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    sb.note_time(t);
  endtask

  // Stops the sender and waits until every pending verdict has come out.
  // Every beat yields a result, so an empty scoreboard means an idle block.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic csm_time_t make_time(input int unsigned yr, input int unsigned mo,
                                          input int unsigned dy, input int unsigned hr,
                                          input int unsigned mi);
    csm_time_t t;
    t.year   = 12'(yr);
    t.month  = 4'(mo);
    t.day    = 5'(dy);
    t.hour   = 5'(hr);
    t.minute = 6'(mi);
    return t;
  endfunction

  // Mostly well-formed times near the present, a share over the whole year
  // range, and a fifth of raw bit patterns that reach every out-of-range code.
  function automatic csm_time_t rand_time();
    csm_time_t t;
    if ($urandom_range(0, 4) == 0) begin
      t = csm_time_t'($urandom);
    end else begin
      t.year   = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 4095))
                                             : 12'($urandom_range(1900, 2200));
      t.month  = 4'($urandom_range(1, 12));
      t.day    = 5'($urandom_range(1, 31));
      t.hour   = 5'($urandom_range(0, 23));
      t.minute = 6'($urandom_range(0, 59));
    end
    return t;
  endfunction

  // Random mask of the given width. Bits above the width carry noise, which
  // the block must drop.
  function automatic logic [CfgDataW-1:0] gen_mask(input int unsigned width);
    logic [63:0] full;
    logic [63:0] bits;
    logic [63:0] noise;
    int unsigned r;
    mask_mode_e  mode;
    full  = (64'd1 << width) - 64'd1;
    noise = {$urandom, $urandom};
    r     = $urandom_range(0, 15);
    mode  = (r == 0) ? MaskZero : (r < 4) ? MaskOnes : (r < 10) ? MaskDense :
            (r < 14) ? MaskRandom : MaskSingle;
    case (mode)
      MaskZero:   bits = '0;
      MaskOnes:   bits = '1;
      MaskDense:  bits = {$urandom, $urandom} | {$urandom, $urandom};
      MaskRandom: bits = {$urandom, $urandom};
      default:    bits = 64'd1 << $urandom_range(0, width - 1);
    endcase
    return CfgDataW'((bits & full) | (noise & ~full));
  endfunction

  // Writes all seven registers, one per cycle, while the block is idle. For
  // random schedules the two wildcard flags come from the phase number so
  // that the phases walk through all four day/weekday rules.
  task automatic program_schedule(input sched_kind_e kind, input int unsigned phase);
    csm_reg_e            idx;
    logic [CfgDataW-1:0] value;
    logic [CfgDataW-1:0] noise;
    for (int i = 0; i < 7; i++) begin
      idx   = csm_reg_e'(i);
      noise = CfgDataW'({$urandom, $urandom});
      if (kind == SchedOnes) begin
        value = '1;
      end else if (kind == SchedZero) begin
        value = '0;
      end else begin
        case (idx)
          RegMinuteMask:  value = gen_mask(MinuteW);
          RegHourMask:    value = gen_mask(HourW);
          RegDayMask:     value = gen_mask(DayW);
          RegMonthMask:   value = gen_mask(MonthW);
          RegWeekdayMask: value = gen_mask(WeekdayW);
          RegDayAny:      value = {noise[CfgDataW-1:1], phase[0]};
          default:        value = {noise[CfgDataW-1:1], phase[1]};
        endcase
      end
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= value;
      @(posedge clk_i);
      sb.set_reg(idx, value);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Field extremes, out-of-range codes, month codes that normalize into a
  // neighboring year, day zero, overlong days, leap and century years, and
  // years before 1900.
  task automatic run_directed();
    send_time(make_time(1900, 1, 1, 0, 0));
    send_time(make_time(4095, 12, 31, 23, 59));
    send_time(make_time(0, 0, 0, 31, 63));
    send_time(make_time(2000, 2, 29, 12, 30));
    send_time(make_time(2024, 13, 5, 1, 1));
    send_time(make_time(2023, 15, 31, 2, 2));
    send_time(make_time(1999, 0, 1, 3, 3));
    send_time(make_time(1600, 3, 0, 4, 4));
    send_time(make_time(4095, 15, 31, 31, 63));
    send_time(make_time(2100, 2, 28, 23, 0));
    send_time(make_time(1901, 4, 31, 0, 59));
    send_time(make_time(3000, 14, 1, 22, 58));
  endtask

  // Every beat that the receiver takes is checked against the oldest
  // prediction. Outputs are sampled at the edge, before the edge's updates.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o);
    end
  end

  // The receiver switches between stall patterns at random. On request it
  // also holds off for a long stretch so the pipeline fills up and has to
  // stall the sender.
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned left;
    m_axis_tready_i <= 1'b0;
    mode = RxAlways;
    left = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(16, 64);
      end
      left--;
      case (mode)
        RxAlways: m_axis_tready_i <= 1'b1;
        RxCoin:   m_axis_tready_i <= 1'($urandom_range(0, 1));
        RxSparse: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        default:  m_axis_tready_i <= ~m_axis_tready_i;
      endcase
      @(posedge clk_i);
    end
  end

  initial begin : stimulus
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= RegMinuteMask;
    cfg_wdata_i     <= '0;
    rst_ni          <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Straight out of reset every mask is empty: nothing may match, but the
    // weekday must still be right.
    run_directed();
    settle();

    // Every value allowed and both fields wildcards: everything in range
    // matches, and only out-of-range codes are refused.
    program_schedule(SchedOnes, 0);
    run_directed();

    // Random schedules. The first phase carries the long receiver hold-off
    // while the sender keeps offering; the last one clears every register.
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      settle();
      program_schedule((phase == RandomPhases - 1) ? SchedZero : SchedRandom, phase);
      if (phase == 0) begin
        hold_off_req = 1'b1;
      end
      repeat (PhaseItems) send_time(rand_time());
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_cron_schedule_match_core passed");
    end else begin
      $display("tb_cron_schedule_match_core failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_cron_schedule_match_core failed");
    $finish;
  end

endmodule

[cron_schedule_match_core.f]
rtl/csm_pkg.sv
rtl/csm_cfg_regs.sv
rtl/csm_input_stage.sv
rtl/csm_field_stage.sv
rtl/csm_weekday_stage.sv
rtl/cron_schedule_match_core.sv
rtl/csm_checker.sv
bench/tb_cron_schedule_match_core.sv
